@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define LFO_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent must hold in the clock cycle after the antecedent
`define LFO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define LFO_ASSERT(lbl, clk, rstn, prop, msg)
`define LFO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ rtl/lfo_pkg.sv @@
package lfo_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int EXP_TABLE_BITS_DEF  = 10;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  // output buffer, power of two
  localparam int OUT_DEPTH = 16;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [OUT_CNT_W-1:0] CNT_FULL = OUT_CNT_W'(OUT_DEPTH);

  localparam logic [30:0] SP_RESET = 31'd89478;
  localparam logic [15:0] PW_RESET = 16'd32768;
  localparam logic [15:0] PW_MIN   = 16'd655;
  localparam logic [15:0] PW_MAX   = 16'd64880;

  localparam logic signed [16:0] PITCH_MAX = 17'sd32768;
  localparam logic signed [15:0] LVL_ONE   = 16'sd1024;
  localparam logic signed [15:0] LVL_ZERO  = 16'sd0;

  localparam logic signed [17:0] Q14_ONE = 18'sd16384;
  localparam logic signed [17:0] Q14_TWO = 18'sd32768;

  localparam logic [15:0] TRI_SH_BI      = 16'd49152;
  localparam logic [15:0] TRI_SH_BI_INV  = 16'd16384;
  localparam logic [15:0] TRI_SH_UNI     = 16'd0;
  localparam logic [15:0] TRI_SH_UNI_INV = 16'd32768;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned SIN_A1  = 64'd1686629713;
  localparam longint unsigned SIN_A3  = 64'd693598670;
  localparam longint unsigned SIN_A5  = 64'd85569306;
  localparam longint unsigned SIN_A7  = 64'd5026995;
  localparam longint unsigned SIN_A9  = 64'd172273;

  typedef enum logic {
    CMD_TICK,
    CMD_LOAD
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SAMPLE_PERIOD,
    REG_PULSE_WIDTH,
    REG_OFFSET_MODE,
    REG_INVERT_MODE
  } reg_idx_t;

  typedef struct packed {
    logic vld;
    logic load;
  } lfo_ctl_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic        offset_mode;
    logic        invert_mode;
  } wave_cfg_t;

  function automatic longint unsigned isqrt64(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned res;
    longint unsigned b;
    v = v_in;
    res = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(f / 2^bits) in unsigned Q1.30, one rounded root multiply per set bit
  function automatic logic [30:0] exp_mant(input int f, input int bits);
    longint unsigned acc;
    longint unsigned r;
    acc = Q30_ONE;
    r = 64'd2 * Q30_ONE;
    for (int j = bits - 1; j >= 0; j--) begin
      r = isqrt64(r << 30);
      if (f[j]) acc = (acc * r + (Q30_ONE >> 1)) >> 30;
    end
    return 31'(acc);
  endfunction

  // sin(pi/2 * i / 2^sbits) in unsigned Q1.14 from the odd degree-9 polynomial
  function automatic logic [14:0] sine_entry(input longint unsigned i, input int sbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    x = i << (30 - sbits);
    x2 = (x * x) >> 30;
    p = SIN_A7 - ((SIN_A9 * x2) >> 30);
    p = SIN_A5 - ((p * x2) >> 30);
    p = SIN_A3 - ((p * x2) >> 30);
    p = SIN_A1 - ((p * x2) >> 30);
    p = (p * x) >> 30;
    p = (p + 64'd32768) >> 16;
    if (p > 64'd16384) p = 64'd16384;
    return 15'(p);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'h7fff;
    if (v < -18'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

endpackage

@@ rtl/lfo_ram.sv @@
module lfo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read at the write edge returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lfo_step.sv @@
module lfo_step #(
  parameter int PHASE_BITS     = lfo_pkg::PHASE_BITS_DEF,
  parameter int EXP_TABLE_BITS = lfo_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lfo_pkg::lfo_ctl_t      in_ctl,
  input  logic signed [16:0]     pitch,
  input  logic signed [15:0]     reset_level,
  input  logic [31:0]            phase_value,
  input  logic [30:0]            sample_period,
  output lfo_pkg::lfo_ctl_t      step_ctl,
  output logic signed [15:0]     step_level,
  output logic [31:0]            step_pv,
  output logic [PHASE_BITS-1:0]  step_inc
);
  import lfo_pkg::*;

  localparam int EXP_ENTRIES = 2 ** EXP_TABLE_BITS;
  // right shift of sample_period * mantissa is 62 - ip - PHASE_BITS, ip = qh - 16
  localparam int SH_BASE = 78 - PHASE_BITS;
  localparam logic [61:0] HALF = 62'(1) << (PHASE_BITS - 1);

  typedef logic [30:0] exp_rom_t [EXP_ENTRIES];

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t t;
    for (int k = 0; k < EXP_ENTRIES; k++) begin
      t[k] = exp_mant(k, EXP_TABLE_BITS);
    end
    return t;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  logic signed [16:0]        pitch_c;
  logic [16:0]               q;
  logic [EXP_TABLE_BITS-1:0] f_idx;
  logic [5:0]                sh_nxt;
  logic [61:0]               prod_nxt;
  logic [61:0]               shifted;
  logic [PHASE_BITS-1:0]     inc_nxt;

  lfo_ctl_t                  ctl1_r, ctl2_r, ctl3_r;
  logic signed [15:0]        lvl1_r, lvl2_r, lvl3_r;
  logic [31:0]               pv1_r, pv2_r, pv3_r;
  logic [5:0]                sh1_r, sh2_r;
  logic [30:0]               mant1_r;
  logic [61:0]               prod2_r;
  logic [PHASE_BITS-1:0]     inc3_r;

  always_comb begin
    pitch_c = (pitch > PITCH_MAX) ? PITCH_MAX : pitch;
    // pitch + 16 octaves, never negative
    q = {~pitch_c[16], pitch_c[15:0]};
    f_idx = q[11 -: EXP_TABLE_BITS];
    sh_nxt = 6'(SH_BASE) - {1'b0, q[16:12]};
  end

  assign prod_nxt = sample_period * mant1_r;

  always_comb begin
    shifted = prod2_r >> sh2_r;
    inc_nxt = (shifted > HALF) ? HALF[PHASE_BITS-1:0] : shifted[PHASE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    lvl1_r  <= reset_level;
    pv1_r   <= phase_value;
    sh1_r   <= sh_nxt;
    mant1_r <= EXP_ROM[f_idx];

    lvl2_r  <= lvl1_r;
    pv2_r   <= pv1_r;
    sh2_r   <= sh1_r;
    prod2_r <= prod_nxt;

    lvl3_r  <= lvl2_r;
    pv3_r   <= pv2_r;
    inc3_r  <= inc_nxt;
  end

  assign step_ctl   = ctl3_r;
  assign step_level = lvl3_r;
  assign step_pv    = pv3_r;
  assign step_inc   = inc3_r;

endmodule

@@ rtl/lfo_phase.sv @@
module lfo_phase #(
  parameter int PHASE_BITS = lfo_pkg::PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lfo_pkg::lfo_ctl_t     step_ctl,
  input  logic signed [15:0]    step_level,
  input  logic [31:0]           step_pv,
  input  logic [PHASE_BITS-1:0] step_inc,
  output logic                  ph_vld,
  output logic [PHASE_BITS-1:0] ph
);
  import lfo_pkg::*;

  // state word: trigger flag above the phase
  localparam int SW = PHASE_BITS + 1;

  logic [SW-1:0]           ram_q;
  logic [SW-1:0]           cur;
  logic [SW-1:0]           state_nxt;
  logic                    cur_trig;
  logic [PHASE_BITS-1:0]   cur_ph;
  logic [PHASE_BITS+31:0]  pv_ext;
  logic [PHASE_BITS-1:0]   base;
  logic                    trig_nxt;
  logic [PHASE_BITS-1:0]   phase_nxt;

  logic                    written_r;
  logic                    last_vld_r;
  logic [SW-1:0]           last_r;

  lfo_ram #(
    .WIDTH (SW),
    .DEPTH (1)
  ) u_state_ram (
    .clk   (clk),
    .we    (step_ctl.vld),
    .waddr ('0),
    .wdata (state_nxt),
    .raddr ('0),
    .rdata (ram_q)
  );

  always_comb begin
    // the registered ram read still returns the old word just after a write, so the last write is forwarded
    if (last_vld_r) begin
      cur = last_r;
    end else if (written_r) begin
      cur = ram_q;
    end else begin
      cur = '0;
    end
    cur_trig = cur[SW-1];
    cur_ph   = cur[PHASE_BITS-1:0];
    pv_ext   = {step_pv, {PHASE_BITS{1'b0}}};

    trig_nxt = cur_trig;
    base     = cur_ph;
    if (step_ctl.load) begin
      phase_nxt = pv_ext[PHASE_BITS+31 -: PHASE_BITS];
    end else begin
      // schmitt trigger: re-arm at or below zero, fire at or above one
      if (cur_trig) begin
        if (step_level <= LVL_ZERO) trig_nxt = 1'b0;
      end else if (step_level >= LVL_ONE) begin
        trig_nxt = 1'b1;
        base     = '0;
      end
      phase_nxt = base + step_inc;
    end
    state_nxt = {trig_nxt, phase_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r  <= 1'b0;
      last_vld_r <= 1'b0;
    end else begin
      last_vld_r <= step_ctl.vld;
      if (step_ctl.vld) written_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step_ctl.vld) last_r <= state_nxt;
  end

  assign ph_vld = last_vld_r;
  assign ph     = last_r[PHASE_BITS-1:0];

endmodule

@@ rtl/lfo_wave.sv @@
module lfo_wave #(
  parameter int PHASE_BITS      = lfo_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = lfo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ph_vld,
  input  logic [PHASE_BITS-1:0] ph,
  input  lfo_pkg::wave_cfg_t    cfg,
  output logic                  wave_vld,
  output logic [15:0]           sine_out,
  output logic [15:0]           triangle_out,
  output logic [15:0]           saw_out,
  output logic [15:0]           square_out,
  output logic [15:0]           light_out
);
  import lfo_pkg::*;

  localparam int SINE_ENTRIES = 2 ** SINE_TABLE_BITS + 1;
  localparam logic [SINE_TABLE_BITS:0] QUARTER = (SINE_TABLE_BITS + 1)'(1) << SINE_TABLE_BITS;

  typedef logic [14:0] sine_rom_t [SINE_ENTRIES];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      t[k] = sine_entry(64'(k), SINE_TABLE_BITS);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [1:0]                 q, qc;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS:0]   s_addr, c_addr;
  logic [15:0]                u;
  logic [14:0]                w;
  logic [15:0]                tri_sh;
  logic [15:0]                y;
  logic [16:0]                d;
  logic [15:0]                pwc;
  logic                       sq_hi;
  logic signed [17:0]         tri_v, saw_b, saw_v, sq_v;
  logic signed [17:0]         s_v, c_v, sine_v;

  logic                       va_r, vb_r;
  logic [14:0]                s_mag_r, c_mag_r;
  logic                       s_neg_r, c_neg_r;
  logic [15:0]                tri_a_r, saw_a_r, sq_a_r;
  logic [15:0]                sine_b_r, tri_b_r, saw_b_r, sq_b_r, light_b_r;

  always_comb begin
    q   = ph[PHASE_BITS-1 -: 2];
    qc  = q + 2'd1;
    idx = ph[PHASE_BITS-3 -: SINE_TABLE_BITS];
    // odd quarters run the table backward
    s_addr = q[0]  ? (QUARTER - {1'b0, idx}) : {1'b0, idx};
    c_addr = qc[0] ? (QUARTER - {1'b0, idx}) : {1'b0, idx};

    u = ph[PHASE_BITS-1 -: 16];
    w = ph[PHASE_BITS-1 -: 15];

    if (cfg.offset_mode) begin
      tri_sh = cfg.invert_mode ? TRI_SH_UNI_INV : TRI_SH_UNI;
    end else begin
      tri_sh = cfg.invert_mode ? TRI_SH_BI_INV : TRI_SH_BI;
    end
    y = u - tri_sh;
    d = y[15] ? (17'h10000 - {1'b0, y}) : {1'b0, y};
    tri_v = cfg.offset_mode ? $signed(18'(d)) : $signed(18'(d)) - Q14_ONE;

    saw_b = w[14] ? $signed(18'(w)) - Q14_TWO : $signed(18'(w));
    if (cfg.offset_mode) begin
      saw_v = cfg.invert_mode ? Q14_TWO - $signed(18'(w)) : $signed(18'(w));
    end else begin
      saw_v = cfg.invert_mode ? -saw_b : saw_b;
    end

    if (cfg.pulse_width < PW_MIN) begin
      pwc = PW_MIN;
    end else if (cfg.pulse_width > PW_MAX) begin
      pwc = PW_MAX;
    end else begin
      pwc = cfg.pulse_width;
    end
    sq_hi = (u < pwc) ^ cfg.invert_mode;
    sq_v  = (sq_hi ? Q14_ONE : -Q14_ONE) + (cfg.offset_mode ? Q14_ONE : 18'sd0);
  end

  always_comb begin
    s_v = s_neg_r ? -$signed(18'(s_mag_r)) : $signed(18'(s_mag_r));
    c_v = c_neg_r ? -$signed(18'(c_mag_r)) : $signed(18'(c_mag_r));
    if (cfg.offset_mode) begin
      sine_v = cfg.invert_mode ? Q14_ONE + c_v : Q14_ONE - c_v;
    end else begin
      sine_v = cfg.invert_mode ? -s_v : s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= ph_vld;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    s_mag_r   <= SINE_ROM[s_addr];
    c_mag_r   <= SINE_ROM[c_addr];
    s_neg_r   <= q[1];
    c_neg_r   <= qc[1];
    tri_a_r   <= sat16(tri_v);
    saw_a_r   <= sat16(saw_v);
    sq_a_r    <= sat16(sq_v);

    sine_b_r  <= sat16(sine_v);
    tri_b_r   <= tri_a_r;
    saw_b_r   <= saw_a_r;
    sq_b_r    <= sq_a_r;
    light_b_r <= sat16(s_v);
  end

  assign wave_vld     = vb_r;
  assign sine_out     = sine_b_r;
  assign triangle_out = tri_b_r;
  assign saw_out      = saw_b_r;
  assign square_out   = sq_b_r;
  assign light_out    = light_b_r;

endmodule

@@ rtl/lfo_phase_waveform_generator.sv @@
// Fixed-point LFO with a 32-bit wrapping phase accumulator. Each input item is either a
// tick (in_tuser = 0: advance the phase by 2^(pitch/4096) * sample_period, capped at half a cycle,
// after a Schmitt trigger on reset_level that zeroes the phase when it fires) or a load
// (in_tuser = 1: set the phase from phase_value). Every item returns one result item with
// sine, triangle, saw, pulse and indicator sine of the new phase, all signed Q2.14.
// An item is taken every clock cycle while in_tready is high; its result passes the step
// pipeline, the phase update and the waveform registers into a 16-entry output buffer. in_tready
// drops only while 16 items are accepted and not yet taken at the output. The phase and
// trigger live in a one-entry state RAM that is read, updated and written back once per
// item; the last write is forwarded so back-to-back ticks see it, and the state is taken as
// zero until the RAM's first write, so no clearing pass follows reset. Configuration registers
// on the APB-style port: 0x0 sample_period, 0x4 pulse_width, 0x8 offset_mode,
// 0xC invert_mode; write them only while no item is in flight.
`include "assert_macros.svh"

module lfo_phase_waveform_generator #(
  parameter int PHASE_BITS      = lfo_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = lfo_pkg::SINE_TABLE_BITS_DEF,
  parameter int EXP_TABLE_BITS  = lfo_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pitch[16:0], reset_level[32:17], phase_value[64:33], zero fill
  input  logic [lfo_pkg::IN_DATA_W-1:0]   in_tdata,
  // command[0]
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // sine_out[15:0], triangle_out[31:16], saw_out[47:32], square_out[63:48],
  // light_out[79:64]
  output logic [lfo_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [3:0]                      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import lfo_pkg::*;

  logic                  in_acc, out_acc, cfg_wr, fifo_push;
  lfo_ctl_t              in_ctl, step_ctl;
  logic signed [15:0]    step_level;
  logic [31:0]           step_pv;
  logic [PHASE_BITS-1:0] step_inc;
  logic                  ph_vld;
  logic [PHASE_BITS-1:0] ph;
  wave_cfg_t             wave_cfg;
  logic [15:0]           sine_w, tri_w, saw_w, sq_w, light_w;
  logic [OUT_DATA_W-1:0] wave_data;

  logic [30:0]           sample_period_r;
  logic [15:0]           pulse_width_r;
  logic                  offset_mode_r;
  logic                  invert_mode_r;
  logic [OUT_CNT_W-1:0]  occ_r, occ_nxt;
  logic [OUT_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OUT_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OUT_DATA_W-1:0] fifo_mem_r [OUT_DEPTH];

  assign in_tready  = (occ_r < CNT_FULL);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_acc    = out_tvalid & out_tready;
  assign out_tdata  = fifo_mem_r[rd_ptr_r];

  assign in_ctl = '{vld: in_acc, load: (in_tuser[0] == CMD_LOAD)};

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= SP_RESET;
      pulse_width_r   <= PW_RESET;
      offset_mode_r   <= 1'b0;
      invert_mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_SAMPLE_PERIOD: sample_period_r <= cfg_pwdata[30:0];
        REG_PULSE_WIDTH:   pulse_width_r   <= cfg_pwdata[15:0];
        REG_OFFSET_MODE:   offset_mode_r   <= cfg_pwdata[0];
        REG_INVERT_MODE:   invert_mode_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_SAMPLE_PERIOD: cfg_prdata = {1'b0, sample_period_r};
      REG_PULSE_WIDTH:   cfg_prdata = {16'd0, pulse_width_r};
      REG_OFFSET_MODE:   cfg_prdata = {31'd0, offset_mode_r};
      REG_INVERT_MODE:   cfg_prdata = {31'd0, invert_mode_r};
      default:           cfg_prdata = '0;
    endcase
  end

  lfo_step #(
    .PHASE_BITS     (PHASE_BITS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ctl        (in_ctl),
    .pitch         (in_tdata[16:0]),
    .reset_level   (in_tdata[32:17]),
    .phase_value   (in_tdata[64:33]),
    .sample_period (sample_period_r),
    .step_ctl      (step_ctl),
    .step_level    (step_level),
    .step_pv       (step_pv),
    .step_inc      (step_inc)
  );

  lfo_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_ctl   (step_ctl),
    .step_level (step_level),
    .step_pv    (step_pv),
    .step_inc   (step_inc),
    .ph_vld     (ph_vld),
    .ph         (ph)
  );

  assign wave_cfg = '{pulse_width: pulse_width_r, offset_mode: offset_mode_r,
                      invert_mode: invert_mode_r};

  lfo_wave #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_wave (
    .clk          (clk),
    .rst_n        (rst_n),
    .ph_vld       (ph_vld),
    .ph           (ph),
    .cfg          (wave_cfg),
    .wave_vld     (fifo_push),
    .sine_out     (sine_w),
    .triangle_out (tri_w),
    .saw_out      (saw_w),
    .square_out   (sq_w),
    .light_out    (light_w)
  );

  assign wave_data = {light_w, sq_w, saw_w, tri_w, sine_w};

  // occupancy counts items from acceptance until taken, so the buffer never overflows
  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) occ_nxt = occ_r + 1'b1;
    if (!in_acc && out_acc) occ_nxt = occ_r - 1'b1;
    cnt_nxt = cnt_r;
    if (fifo_push && !out_acc) cnt_nxt = cnt_r + 1'b1;
    if (!fifo_push && out_acc) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      cnt_r <= cnt_nxt;
      if (fifo_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (out_acc) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) fifo_mem_r[wr_ptr_r] <= wave_data;
  end

  `LFO_ASSERT(a_fifo_no_overflow, clk, rst_n, !(fifo_push && !out_acc && (cnt_r == CNT_FULL)), "output buffer overflow")
  `LFO_ASSERT(a_occ_covers_fifo, clk, rst_n, occ_r >= cnt_r, "buffered items exceed accepted items")
  `LFO_ASSERT_NEXT(a_step_to_phase, clk, rst_n, step_ctl.vld, ph_vld, "phase update lost an item")

endmodule

@@ tb/sv/lfo_wave_checker.sv @@
`timescale 1ns / 100ps

module lfo_wave_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  // pitch[16:0], reset_level[32:17], phase_value[64:33], zero fill
  input  logic [lfo_pkg::IN_DATA_W-1:0] in_tdata,
  // command[0]
  input  logic [0:0]                    in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  // sine_out[15:0], triangle_out[31:16], saw_out[47:32], square_out[63:48],
  // light_out[79:64]
  input  logic [lfo_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [3:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  input  logic                          cfg_pready,
  output int                            fail_cnt,
  output int                            pending_cnt,
  output int                            checked_cnt
);
  import lfo_pkg::*;

  typedef struct packed {
    logic [6:0]  fill;
    logic [31:0] phase_value;
    logic [15:0] reset_level;
    logic [16:0] pitch;
  } lfo_item_t;

  typedef struct packed {
    logic [15:0] light;
    logic [15:0] square;
    logic [15:0] saw;
    logic [15:0] triangle;
    logic [15:0] sine;
  } wave_set_t;

  wave_set_t exp_waves_q[$];

  // oscillator state and register copies
  logic [31:0] phase_q;
  logic        trig_high;
  logic [30:0] period_cfg;
  logic [15:0] pulse_cfg;
  logic        offset_cfg;
  logic        invert_cfg;

  int              sine_lut[0:1024];
  longint unsigned mant_lut[0:1023];

  initial begin
    fail_cnt = 0;
    pending_cnt = 0;
    checked_cnt = 0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned cand;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  function automatic int poly_sine(int i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    x = longint'(i) << 20;
    x2 = (x * x) >> 30;
    p = SIN_A7 - ((SIN_A9 * x2) >> 30);
    p = SIN_A5 - ((p * x2) >> 30);
    p = SIN_A3 - ((p * x2) >> 30);
    p = SIN_A1 - ((p * x2) >> 30);
    p = (p * x) >> 30;
    p = (p + 64'd32768) >> 16;
    if (p > 64'd16384) p = 64'd16384;
    return int'(p);
  endfunction

  // lookup tables: quarter sine and 2^(f/1024) mantissa built from chained roots of two
  initial begin
    longint unsigned roots[10];
    longint unsigned r;
    longint unsigned acc;
    for (int i = 0; i <= 1024; i++) sine_lut[i] = poly_sine(i);
    r = 64'd2 * Q30_ONE;
    for (int j = 9; j >= 0; j--) begin
      r = floor_sqrt(r << 30);
      roots[j] = r;
    end
    for (int f = 0; f < 1024; f++) begin
      acc = Q30_ONE;
      for (int j = 9; j >= 0; j--)
        if (f[j]) acc = (acc * roots[j] + (Q30_ONE >> 1)) >> 30;
      mant_lut[f] = acc;
    end
  end

  function automatic int quarter_sine(logic [31:0] ph);
    int i;
    int mag;
    i = int'(ph[29:20]);
    if (ph[30]) i = 1024 - i;
    mag = sine_lut[i];
    return ph[31] ? -mag : mag;
  endfunction

  function automatic logic [15:0] clip16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic wave_set_t predict_waves(cmd_t cmd, lfo_item_t it);
    wave_set_t res;
    int pitch_i;
    int lvl;
    int oct;
    int frac;
    int s;
    int c;
    int sine_v;
    int tri_v;
    int saw_v;
    int sq_v;
    int d;
    int w;
    int pwc;
    int unsigned qv;
    longint unsigned prod;
    longint unsigned stp;
    logic [15:0] u;
    logic [15:0] shift;
    logic [15:0] y;

    if (cmd == CMD_LOAD) begin
      phase_q = it.phase_value;
    end else begin
      pitch_i = $signed(it.pitch);
      lvl = $signed(it.reset_level);
      // schmitt trigger acts before the advance
      if (trig_high) begin
        if (lvl <= 0) trig_high = 1'b0;
      end else if (lvl >= 1024) begin
        trig_high = 1'b1;
        phase_q = '0;
      end
      if (pitch_i > 32768) pitch_i = 32768;
      qv = pitch_i + 65536;
      oct = int'(qv >> 12) - 16;
      frac = int'((qv & 4095) >> 2);
      prod = {33'd0, period_cfg} * mant_lut[frac];
      stp = prod >> (30 - oct);
      if (stp > 64'h8000_0000) stp = 64'h8000_0000;
      phase_q = phase_q + stp[31:0];
    end

    u = phase_q[31:16];
    w = int'(phase_q[31:17]);
    s = quarter_sine(phase_q);
    c = quarter_sine(phase_q + 32'h4000_0000);

    if (offset_cfg) sine_v = invert_cfg ? 16384 + c : 16384 - c;
    else sine_v = invert_cfg ? -s : s;

    if (offset_cfg) shift = invert_cfg ? TRI_SH_UNI_INV : TRI_SH_UNI;
    else shift = invert_cfg ? TRI_SH_BI_INV : TRI_SH_BI;
    y = u - shift;
    d = (y < 16'd32768) ? int'(y) : 65536 - int'(y);
    tri_v = offset_cfg ? d : d - 16384;

    if (offset_cfg) begin
      saw_v = invert_cfg ? 32768 - w : w;
    end else begin
      saw_v = (w < 16384) ? w : w - 32768;
      if (invert_cfg) saw_v = -saw_v;
    end

    pwc = int'(pulse_cfg);
    if (pwc < int'(PW_MIN)) pwc = int'(PW_MIN);
    if (pwc > int'(PW_MAX)) pwc = int'(PW_MAX);
    sq_v = ((int'(u) < pwc) ^ invert_cfg) ? 16384 : -16384;
    if (offset_cfg) sq_v += 16384;

    res.sine = clip16(sine_v);
    res.triangle = clip16(tri_v);
    res.saw = clip16(saw_v);
    res.square = clip16(sq_v);
    res.light = clip16(s);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h expected %h",
                                checked_cnt, name, got, want));
  endtask

  always @(posedge clk) begin
    wave_set_t got;
    wave_set_t want;
    if (!rst_n) begin
      phase_q = '0;
      trig_high = 1'b0;
      period_cfg = SP_RESET;
      pulse_cfg = PW_RESET;
      offset_cfg = 1'b0;
      invert_cfg = 1'b0;
      exp_waves_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_SAMPLE_PERIOD: period_cfg = cfg_pwdata[30:0];
          REG_PULSE_WIDTH:   pulse_cfg = cfg_pwdata[15:0];
          REG_OFFSET_MODE:   offset_cfg = cfg_pwdata[0];
          REG_INVERT_MODE:   invert_cfg = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (exp_waves_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no item pending", out_tdata));
        end else begin
          want = exp_waves_q.pop_front();
          check_field("sine_out", got.sine, want.sine);
          check_field("triangle_out", got.triangle, want.triangle);
          check_field("saw_out", got.saw, want.saw);
          check_field("square_out", got.square, want.square);
          check_field("light_out", got.light, want.light);
        end
        checked_cnt++;
      end
      if (in_tvalid && in_tready)
        exp_waves_q.push_back(predict_waves(cmd_t'(in_tuser[0]), lfo_item_t'(in_tdata)));
    end
    pending_cnt <= exp_waves_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import lfo_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 225;
  localparam int HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [3:0]            cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_len = 0;
  int sent_items = 0;
  int load_items = 0;
  int settings_cnt = 0;
  int unsigned quiet_cycles = 0;

  always #1 clk = ~clk;

  lfo_phase_waveform_generator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lfo_wave_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .checked_cnt (checked_cnt)
  );

  // result side: random back-pressure, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len <= 0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results pending",
               QUIET_LIMIT, pending_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(cmd_t cmd, logic [16:0] pitch, logic [15:0] lvl,
                           logic [31:0] pv);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {7'd0, pv, lvl, pitch};
    do @(posedge clk); while (!in_tready);
    sent_items++;
    if (cmd == CMD_LOAD) load_items++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic write_settings(logic [30:0] period, logic [15:0] width, logic offs,
                                logic inv);
    cfg_write(REG_SAMPLE_PERIOD, {1'b0, period});
    cfg_write(REG_PULSE_WIDTH, {16'd0, width});
    cfg_write(REG_OFFSET_MODE, {31'd0, offs});
    cfg_write(REG_INVERT_MODE, {31'd0, inv});
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    settings_cnt++;
  endtask

  initial begin
    int roll;
    logic [16:0] pitch;
    logic [15:0] lvl;
    logic [31:0] pv;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 22;
    rx_idle_pct = 64;

    // directed: pitch extremes and the cap, trigger hysteresis, quarter-cycle loads
    send_item(CMD_TICK, 17'd0, 16'd0, 32'd0);
    send_item(CMD_TICK, 17'h00fff, 16'd0, 32'd0);
    send_item(CMD_TICK, 17'h0ffff, 16'd0, 32'd0);
    send_item(CMD_TICK, 17'h08000, 16'd0, 32'd0);
    send_item(CMD_TICK, 17'h08001, 16'd0, 32'd0);
    send_item(CMD_TICK, 17'h10000, 16'd0, 32'd0);
    send_item(CMD_TICK, 17'd0, 16'd1024, 32'd0);
    send_item(CMD_TICK, 17'd4096, 16'd1023, 32'd0);
    send_item(CMD_TICK, 17'd4096, 16'h7fff, 32'd0);
    send_item(CMD_TICK, 17'd4096, 16'd1, 32'd0);
    send_item(CMD_TICK, 17'd4096, 16'd0, 32'd0);
    send_item(CMD_TICK, 17'd4096, 16'h8000, 32'd0);
    send_item(CMD_TICK, 17'd4096, 16'd1023, 32'd0);
    send_item(CMD_TICK, 17'd4096, 16'h7fff, 32'd0);
    send_item(CMD_LOAD, 17'($urandom), 16'($urandom), 32'h0000_0000);
    send_item(CMD_LOAD, 17'($urandom), 16'($urandom), 32'hffff_ffff);
    send_item(CMD_LOAD, 17'($urandom), 16'($urandom), 32'h4000_0000);
    send_item(CMD_LOAD, 17'($urandom), 16'($urandom), 32'h8000_0000);
    send_item(CMD_LOAD, 17'($urandom), 16'($urandom), 32'hc000_0000);
    send_item(CMD_LOAD, 17'($urandom), 16'($urandom), 32'h3fff_ffff);
    send_item(CMD_LOAD, 17'($urandom), 16'h7fff, 32'h7fff_ffff);
    send_item(CMD_TICK, 17'h1ffff, 16'hffff, 32'd0);
    send_item(CMD_LOAD, 17'd0, 16'd0, 32'h0001_0000);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        tx_idle_pct = 64;
        rx_idle_pct = 22;
      end else if (ph == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      drain();
      case (ph)
        0: write_settings(31'($urandom_range(400000, 20000)), 16'($urandom), 1'b0, 1'b0);
        1: write_settings(31'h7fff_ffff, 16'd0, 1'b1, 1'b0);
        2: write_settings(31'd1, 16'hffff, 1'b0, 1'b1);
        3: write_settings(31'd0, PW_MIN, 1'b1, 1'b1);
        4: write_settings(31'($urandom), PW_MAX, 1'b0, 1'b0);
        5: write_settings(31'($urandom_range(5000000, 1)), 16'($urandom), 1'($urandom),
                          1'($urandom));
        6: write_settings(31'h7fff_ffff, 16'($urandom), 1'b0, 1'b1);
        default: write_settings(SP_RESET, 16'($urandom), 1'b1, 1'b0);
      endcase
      // long result-side stall while items keep coming, so the input backs up
      if (ph == 6) hold_len <= HOLD_CYCLES;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          pv = ($urandom_range(3) == 0) ? {2'($urandom), 30'd0} : $urandom;
          send_item(CMD_LOAD, 17'($urandom), 16'($urandom), pv);
        end else begin
          roll = $urandom_range(99);
          pitch = (roll < 20) ? 17'($urandom)
                              : 17'(int'($urandom_range(72768)) - 40000);
          // mostly inside the hysteresis band, with gate pulses on either side
          roll = $urandom_range(99);
          if (roll < 8) lvl = 16'($urandom_range(32767, 1024));
          else if (roll < 16) lvl = 16'(-int'($urandom_range(32768)));
          else if (roll < 20) lvl = 16'($urandom);
          else lvl = 16'($urandom_range(1023, 1));
          send_item(CMD_TICK, pitch, lvl, $urandom);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("sent %0d items (%0d phase loads, %0d ticks) under %0d register settings",
             sent_items, load_items, sent_items - load_items, settings_cnt);
    $display("compared %0d results field by field, %0d mismatches", checked_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lfo_pkg.sv
rtl/lfo_ram.sv
rtl/lfo_step.sv
rtl/lfo_phase.sv
rtl/lfo_wave.sv
rtl/lfo_phase_waveform_generator.sv
tb/sv/lfo_wave_checker.sv
tb/sv/tb_top.sv
